@@ src/assert_macros.svh @@
// Assertion helpers shared by the RTL.
// Both sample on the rising edge of clk and are quiet while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every clock edge.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never holds.
`define ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

@@ src/hcbp_pkg.sv @@
`timescale 1ns / 1ps

package hcbp_pkg;

  localparam int MAX_CODE_LEN = 24;
  localparam int SYMBOL_COUNT = 256;
  localparam int BYTE_W       = 8;
  localparam int CODE_W       = 24;
  localparam int LEN_W        = 5;
  localparam int SYM_W        = 8;
  localparam int PEND_W       = BYTE_W - 1;
  localparam int PCNT_W       = 3;
  localparam int VB_W         = 4;
  localparam int ACC_W        = CODE_W + PEND_W;
  localparam int LEN_LIMIT    = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;
  localparam int TBL_AW       = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;

  // Opcodes of the input item
  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_ENCODE = 2'd1;
  localparam logic [1:0] OP_FINISH = 2'd2;

  typedef struct packed {
    logic [1:0]        op;
    logic [SYM_W-1:0]  symbol;
    logic [CODE_W-1:0] code_bits;
    logic [LEN_W-1:0]  code_length;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic [VB_W-1:0]   valid_bits;
    logic              last;
  } out_item_t;

  // One code table entry: saturated length and masked code bits
  typedef struct packed {
    logic [LEN_W-1:0]  len;
    logic [CODE_W-1:0] bits;
  } tbl_entry_t;

endpackage

@@ src/huffman_code_bit_packer.sv @@
`timescale 1ns / 1ps
// Table-driven prefix-code encoder packing codes into bytes, earliest bit in bit 0.
// Input channel in_valid/in_ready/in_item: op LOAD writes the code table entry at
// symbol (length saturated to 24, stray bits above the length dropped); ENCODE
// appends that symbol's code to the stream; FINISH emits the partial last byte
// with its valid bit count and last set, then starts a new stream. Op 3 is a no-op.
// Output channel out_valid/out_ready/out_item carries one byte per item.
// The bytes of an item pass through the table read register, then the byte queue
// register, before they reach the output port.
// Throughput: an item producing at most one byte is taken every cycle while the
// receiver takes each byte; an encode that completes n bytes (n up to 3) holds the byte
// queue until the output port has drained them, one byte per cycle when not stalled.
// Reset (rst_n low, synchronous) empties the pipeline and the pending bit register;
// the code table is not cleared and must be loaded before its entries are encoded.
// When the receiver stalls, the byte queue holds, the lookup stage waits behind it
// and in_ready drops; items that produce no byte still flow past a stalled queue.
// Configuration: none.

`include "assert_macros.svh"

module huffman_code_bit_packer (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  hcbp_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output hcbp_pkg::out_item_t out_item
);

  localparam int BW  = hcbp_pkg::BYTE_W;
  localparam int CW  = hcbp_pkg::CODE_W;
  localparam int LW  = hcbp_pkg::LEN_W;
  localparam int PW  = hcbp_pkg::PEND_W;
  localparam int AW  = hcbp_pkg::ACC_W;
  localparam int QW  = 3 * BW;

  // ---------------------------------------------------------------
  // Accept side: table write for loads, table read for every item
  // ---------------------------------------------------------------
  logic                  in_fire;
  logic                  in_sym_ok;
  logic [LW-1:0]         ld_len;
  logic [CW-1:0]         ld_mask;
  hcbp_pkg::tbl_entry_t  wr_entry;
  hcbp_pkg::tbl_entry_t  rd_entry;

  assign in_fire   = in_valid && in_ready;
  assign in_sym_ok = ({1'b0, in_item.symbol} < (hcbp_pkg::SYM_W + 1)'(hcbp_pkg::SYMBOL_COUNT));

  // Saturate the length and drop code bits at or above it
  always_comb begin
    ld_len = (in_item.code_length > LW'(hcbp_pkg::LEN_LIMIT)) ?
             LW'(hcbp_pkg::LEN_LIMIT) : in_item.code_length;
    for (int i = 0; i < CW; i++) begin
      ld_mask[i] = (LW'(i) < ld_len);
    end
    wr_entry.len  = ld_len;
    wr_entry.bits = in_item.code_bits & ld_mask;
  end

  hcbp_code_table u_table (
    .clk     (clk),
    .wr_en   (in_fire && (in_item.op == hcbp_pkg::OP_LOAD) && in_sym_ok),
    .wr_addr (in_item.symbol[hcbp_pkg::TBL_AW-1:0]),
    .wr_data (wr_entry),
    .rd_en   (in_fire),
    .rd_addr (in_item.symbol[hcbp_pkg::TBL_AW-1:0]),
    .rd_data (rd_entry)
  );

  // ---------------------------------------------------------------
  // Lookup stage: op and range flag alongside the table read data
  // ---------------------------------------------------------------
  logic       s1_valid_r, s1_valid_nxt;
  logic [1:0] s1_op_r;
  logic       s1_sym_ok_r;
  logic       s1_adv;

  // Pending bits of the current stream, earliest in bit 0
  logic [PW-1:0]               pend_bits_r, pend_bits_nxt;
  logic [hcbp_pkg::PCNT_W-1:0] pend_cnt_r, pend_cnt_nxt;

  // Byte queue feeding the output port
  logic [QW-1:0]             q_data_r, q_data_nxt;
  logic [1:0]                q_cnt_r, q_cnt_nxt;
  logic                      q_fin_r, q_fin_nxt;
  logic [hcbp_pkg::VB_W-1:0] q_vb_r, q_vb_nxt;
  logic                      q_free;
  logic                      out_fire;

  // Packing of the looked-up code onto the pending bits
  logic          enc_go;
  logic [AW-1:0] acc;
  logic [LW-1:0] total;
  logic [1:0]    nb;
  logic [AW-1:0] acc_rem;
  logic [1:0]    s1_nb;

  always_comb begin
    enc_go  = (s1_op_r == hcbp_pkg::OP_ENCODE) && s1_sym_ok_r && (rd_entry.len != '0);
    acc     = AW'(pend_bits_r) | (AW'(rd_entry.bits) << pend_cnt_r);
    total   = LW'(pend_cnt_r) + rd_entry.len;
    nb      = total[LW-1:3];
    acc_rem = acc >> {nb, 3'b000};
    unique case (s1_op_r)
      hcbp_pkg::OP_ENCODE: s1_nb = enc_go ? nb : 2'd0;
      hcbp_pkg::OP_FINISH: s1_nb = 2'd1;
      default:             s1_nb = 2'd0;
    endcase
  end

  assign out_fire = out_valid && out_ready;
  // Queue is free if empty, or about to hand over its only byte
  assign q_free   = (q_cnt_r == 2'd0) || ((q_cnt_r == 2'd1) && out_ready);
  // Items without bytes never wait on the queue
  assign s1_adv   = s1_valid_r && ((s1_nb == 2'd0) || q_free);
  assign in_ready = !s1_valid_r || s1_adv;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_op_r     <= in_item.op;
      s1_sym_ok_r <= in_sym_ok;
    end
  end

  // Advance the pending bits when the item leaves the lookup stage
  always_comb begin
    pend_bits_nxt = pend_bits_r;
    pend_cnt_nxt  = pend_cnt_r;
    if (s1_adv) begin
      if (enc_go) begin
        pend_bits_nxt = acc_rem[PW-1:0];
        pend_cnt_nxt  = total[2:0];
      end else if (s1_op_r == hcbp_pkg::OP_FINISH) begin
        pend_bits_nxt = '0;
        pend_cnt_nxt  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_bits_r <= '0;
      pend_cnt_r  <= '0;
    end else begin
      pend_bits_r <= pend_bits_nxt;
      pend_cnt_r  <= pend_cnt_nxt;
    end
  end

  // Load the queue with new bytes, or drop the head byte once taken
  always_comb begin
    q_data_nxt = q_data_r;
    q_cnt_nxt  = q_cnt_r;
    q_fin_nxt  = q_fin_r;
    q_vb_nxt   = q_vb_r;
    if (s1_adv && (s1_nb != 2'd0)) begin
      q_cnt_nxt = s1_nb;
      if (s1_op_r == hcbp_pkg::OP_FINISH) begin
        q_data_nxt = QW'(pend_bits_r);
        q_fin_nxt  = 1'b1;
        q_vb_nxt   = hcbp_pkg::VB_W'(pend_cnt_r);
      end else begin
        q_data_nxt = acc[QW-1:0];
        q_fin_nxt  = 1'b0;
        q_vb_nxt   = hcbp_pkg::VB_W'(BW);
      end
    end else if (out_fire) begin
      q_data_nxt = q_data_r >> BW;
      q_cnt_nxt  = q_cnt_r - 2'd1;
      q_fin_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_cnt_r <= '0;
      q_fin_r <= 1'b0;
    end else begin
      q_cnt_r <= q_cnt_nxt;
      q_fin_r <= q_fin_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_data_r <= q_data_nxt;
    q_vb_r   <= q_vb_nxt;
  end

  assign out_valid           = (q_cnt_r != 2'd0);
  assign out_item.out_byte   = q_data_r[BW-1:0];
  assign out_item.valid_bits = q_fin_r ? q_vb_r : hcbp_pkg::VB_W'(BW);
  assign out_item.last       = q_fin_r;

  // ---------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------
  `ASSERT_NEVER(a_pend_clean, (pend_bits_r >> pend_cnt_r) != '0, "pending bits above count")
  `ASSERT_NEVER(a_fin_single, q_fin_r && (q_cnt_r != 2'd1), "finish byte not alone in queue")
  `ASSERT_NEVER(a_no_overrun, s1_adv && (s1_nb != 2'd0) && (q_cnt_r > 2'd1), "queue overrun")
  `ASSERT_CLK(a_s1_hold, (s1_valid_r && !s1_adv) |=> s1_valid_r, "lookup stage item lost")

endmodule

@@ src/hcbp_code_table.sv @@
`timescale 1ns / 1ps

module hcbp_code_table (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [hcbp_pkg::TBL_AW-1:0] wr_addr,
  input  hcbp_pkg::tbl_entry_t      wr_data,
  input  logic                      rd_en,
  input  logic [hcbp_pkg::TBL_AW-1:0] rd_addr,
  output hcbp_pkg::tbl_entry_t      rd_data
);

  hcbp_pkg::tbl_entry_t mem [hcbp_pkg::SYMBOL_COUNT];
  hcbp_pkg::tbl_entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read; hold the data while no new read is issued
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ verif/hcbp_stream_checker.sv @@
`timescale 1ns / 1ps

module hcbp_stream_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  hcbp_pkg::in_item_t  in_item,
  input  logic                out_valid,
  input  logic                out_ready,
  input  hcbp_pkg::out_item_t out_item,
  output int                  mismatches,
  output int                  bytes_pending,
  output int                  bytes_checked
);
  import hcbp_pkg::*;

  tbl_entry_t        code_tbl [SYMBOL_COUNT];
  logic [PEND_W-1:0] pend_bits = '0;
  logic [PCNT_W-1:0] pend_cnt  = '0;
  out_item_t         byte_q [$];
  int                err_cnt   = 0;
  int                match_cnt = 0;

  initial begin
    foreach (code_tbl[i]) code_tbl[i] = '0;
  end

  // Update the table and bit accumulator for one accepted item, queue its bytes.
  task automatic predict_bytes(input in_item_t it);
    tbl_entry_t       ent;
    logic [ACC_W-1:0] acc;
    int               total;
    out_item_t        b;
    case (it.op)
      OP_LOAD: begin
        ent.len  = (it.code_length > LEN_LIMIT) ? LEN_W'(LEN_LIMIT) : it.code_length;
        ent.bits = it.code_bits & ~({CODE_W{1'b1}} << ent.len);
        code_tbl[it.symbol] = ent;
      end
      OP_ENCODE: begin
        ent = code_tbl[it.symbol];
        if (ent.len != '0) begin
          // bits above the running count are already zero
          acc   = (ACC_W'(ent.bits) << pend_cnt) | ACC_W'(pend_bits);
          total = int'(pend_cnt) + int'(ent.len);
          while (total >= BYTE_W) begin
            b.out_byte   = acc[BYTE_W-1:0];
            b.valid_bits = VB_W'(BYTE_W);
            b.last       = 1'b0;
            byte_q.push_back(b);
            acc   = acc >> BYTE_W;
            total = total - BYTE_W;
          end
          pend_cnt  = PCNT_W'(total);
          pend_bits = acc[PEND_W-1:0];
        end
      end
      OP_FINISH: begin
        b.out_byte   = {1'b0, pend_bits};
        b.valid_bits = VB_W'(pend_cnt);
        b.last       = 1'b1;
        byte_q.push_back(b);
        pend_bits = '0;
        pend_cnt  = '0;
      end
      default: ;
    endcase
  endtask

  task automatic compare_byte(input out_item_t got);
    out_item_t want;
    if (byte_q.size() == 0) begin
      err_cnt++;
      $display("%0t: byte with nothing expected, expected none, got %h/%0d/%0b",
               $time, got.out_byte, got.valid_bits, got.last);
    end else begin
      want = byte_q.pop_front();
      if (got.out_byte !== want.out_byte) begin
        err_cnt++;
        $display("%0t: out_byte expected %h, got %h", $time, want.out_byte, got.out_byte);
      end
      if (got.valid_bits !== want.valid_bits) begin
        err_cnt++;
        $display("%0t: valid_bits expected %0d, got %0d", $time, want.valid_bits,
                 got.valid_bits);
      end
      if (got.last !== want.last) begin
        err_cnt++;
        $display("%0t: last expected %b, got %b", $time, want.last, got.last);
      end
      match_cnt++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      pend_bits = '0;
      pend_cnt  = '0;
    end else begin
      if (in_valid && in_ready) predict_bytes(in_item);
      if (out_valid && out_ready) compare_byte(out_item);
    end
    mismatches    <= err_cnt;
    bytes_pending <= byte_q.size();
    bytes_checked <= match_cnt;
  end

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import hcbp_pkg::*;

  // op 3 has no meaning in the block; it must vanish without a byte
  localparam logic [1:0] OP_NOP = 2'd3;
  localparam int HOLD_CYCLES = 80;   // length of the long receiver hold-off
  localparam int PHASE_ITEMS = 17;   // counted items per idling phase
  localparam int BURST_ITEMS = 14;   // encodes pushed against the hold-off

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_item   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;

  // Idling controls: sender gap chance and receiver stall chance, in percent
  int   idle_pct   = 0;
  int   stall_pct  = 0;
  logic hold_req   = 1'b0;
  int   hold_count = 0;

  int mismatches;
  int bytes_pending;
  int bytes_checked;
  int n_load   = 0;
  int n_encode = 0;
  int n_finish = 0;
  int n_nop    = 0;

  // Symbols whose table entry has been written; only these are ever encoded
  bit               sym_loaded [SYMBOL_COUNT];
  logic [SYM_W-1:0] loaded_syms [$];

  always #6 clk = ~clk;

  huffman_code_bit_packer u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  hcbp_stream_checker u_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_item       (in_item),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_item      (out_item),
    .mismatches    (mismatches),
    .bytes_pending (bytes_pending),
    .bytes_checked (bytes_checked)
  );

  // Receiver: stall at random, except during the one long hold-off, which is
  // counted here so the sender keeps offering items while the block backs up.
  always @(posedge clk) begin
    if (hold_req && hold_count < HOLD_CYCLES) begin
      out_ready  <= 1'b0;
      hold_count <= hold_count + 1;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Offer one item: insert random gaps first, then hold valid and payload until
  // the handshake completes. Valid is only lowered when a gap follows, so it
  // never gets two assignments in one step.
  task automatic send_fields(input logic [1:0] op, input logic [SYM_W-1:0] sym,
                             input logic [CODE_W-1:0] bits,
                             input logic [LEN_W-1:0] len);
    in_item_t it;
    it.op          = op;
    it.symbol      = sym;
    it.code_bits   = bits;
    it.code_length = len;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    case (op)
      OP_LOAD: begin
        n_load++;
        if (!sym_loaded[sym]) begin
          sym_loaded[sym] = 1'b1;
          loaded_syms.push_back(sym);
        end
      end
      OP_ENCODE: n_encode++;
      OP_FINISH: n_finish++;
      default:   n_nop++;
    endcase
  endtask

  // One random item: mostly encodes of loaded symbols, some loads with lengths
  // of every kind (zero, legal, too long), finishes and a little noise.
  task automatic send_random(output bit counted);
    int               pick;
    int               lsel;
    logic [LEN_W-1:0] len;
    pick = $urandom_range(99);
    lsel = $urandom_range(99);
    if (lsel < 8)
      len = '0;
    else if (lsel < 18)
      len = LEN_W'($urandom_range(31, 25));
    else
      len = LEN_W'($urandom_range(24, 1));
    counted = 1'b1;
    if (pick < 18) begin
      send_fields(OP_LOAD, SYM_W'($urandom_range(255)), CODE_W'($urandom), len);
    end else if (pick < 80) begin
      send_fields(OP_ENCODE, loaded_syms[$urandom_range(loaded_syms.size() - 1)],
                  CODE_W'($urandom), len);
    end else if (pick < 93) begin
      send_fields(OP_FINISH, SYM_W'($urandom), CODE_W'($urandom), len);
    end else begin
      counted = 1'b0;
      send_fields(OP_NOP, SYM_W'($urandom), CODE_W'($urandom), LEN_W'($urandom));
    end
  endtask

  task automatic run_phase(input int idle, input int stall);
    int sent;
    bit counted;
    sent      = 0;
    idle_pct  = idle;
    stall_pct <= stall;
    while (sent < PHASE_ITEMS) begin
      send_random(counted);
      if (counted) sent++;
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, no idling.
    // Finish straight after reset: empty byte, zero valid bits.
    send_fields(OP_FINISH, 8'h00, 24'h000000, 5'd0);
    // Unused opcode with every field bit high: drop silently
    send_fields(OP_NOP, 8'hff, 24'hffffff, 5'd31);
    // Table loads: full-length code, stray bits above a 1-bit code, lengths
    // above the limit (saturate), zero length, and an all-zero code
    send_fields(OP_LOAD, 8'd0,   24'hffffff, 5'd24);
    send_fields(OP_LOAD, 8'd255, 24'hffffff, 5'd1);
    send_fields(OP_LOAD, 8'd1,   24'ha5a5a5, 5'd31);
    send_fields(OP_LOAD, 8'd2,   24'h123456, 5'd0);
    send_fields(OP_LOAD, 8'd3,   24'h000000, 5'd7);
    send_fields(OP_LOAD, 8'd4,   24'h5a3c96, 5'd24);
    send_fields(OP_LOAD, 8'd5,   24'h000001, 5'd25);
    // 1 + 7 bits: exactly one byte
    send_fields(OP_ENCODE, 8'd255, 24'h000000, 5'd0);
    send_fields(OP_ENCODE, 8'd3,   24'h000000, 5'd0);
    // Zero-length code: nothing out, state held
    send_fields(OP_ENCODE, 8'd2,   24'h000000, 5'd0);
    // 7 pending plus 24 bits: three bytes, 7 left over, then a 7-bit finish
    send_fields(OP_ENCODE, 8'd3,   24'h000000, 5'd0);
    send_fields(OP_ENCODE, 8'd0,   24'h000000, 5'd0);
    send_fields(OP_FINISH, 8'h00,  24'h000000, 5'd0);
    // Saturated code on a fresh stream, then an empty finish
    send_fields(OP_ENCODE, 8'd1,   24'h000000, 5'd0);
    send_fields(OP_FINISH, 8'h00,  24'h000000, 5'd0);
    // Partial final byte with a single valid bit
    send_fields(OP_ENCODE, 8'd4,   24'h000000, 5'd0);
    send_fields(OP_ENCODE, 8'd255, 24'h000000, 5'd0);
    send_fields(OP_FINISH, 8'h00,  24'h000000, 5'd0);
    send_fields(OP_ENCODE, 8'd5,   24'h000000, 5'd0);
    send_fields(OP_ENCODE, 8'd255, 24'h000000, 5'd0);
    send_fields(OP_FINISH, 8'h00,  24'h000000, 5'd0);

    // Back-pressure: hold the receiver off and keep feeding long codes until
    // the byte queue fills and the input stalls.
    hold_req <= 1'b1;
    for (int i = 0; i < BURST_ITEMS; i++)
      send_fields(OP_ENCODE, (i % 2 == 0) ? 8'd0 : 8'd4, 24'h000000, 5'd0);

    // Random part across the idling phases
    run_phase(0, 0);
    run_phase(61, 0);
    run_phase(0, 61);
    run_phase(16, 16);

    // Drain: wait for every expected byte, then watch a while for extras
    in_valid <= 1'b0;
    @(posedge clk);
    while (bytes_pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("Sent %0d loads, %0d encodes, %0d finishes, %0d unused opcodes; %0d bytes checked",
             n_load, n_encode, n_finish, n_nop, bytes_checked);
    $display("Idling: none, sender 61%%, receiver 61%%, both 16%%, one %0d-cycle hold-off",
             HOLD_CYCLES);
    if (mismatches == 0 && bytes_pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #2400000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+src
src/hcbp_pkg.sv
src/hcbp_code_table.sv
src/huffman_code_bit_packer.sv
verif/hcbp_stream_checker.sv
verif/testbench.sv
